// ----- sv/vst_pkg.sv -----
// ----------------------------------------------------------------------------
// vst_pkg
// Shared types and constants of the value set table: beat payloads, opcodes,
// controller states and the command and status bundles between the modules.
// ----------------------------------------------------------------------------
package vst_pkg;

  // opcodes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam int VALUE_W = 64;
  localparam int COUNT_W = 5;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [VALUE_W-1:0] value;
  } vst_in_t;

  typedef struct packed {
    logic               found;
    logic               status;
    logic [COUNT_W-1:0] entry_count;
  } vst_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } vst_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture the input beat, clear scan state
    logic exec;     // single-cycle work: append on insert
    logic scan;     // one step of the entry walk
    logic close;    // commit the compacted count
    logic publish;  // load the result register
  } vst_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_scan;    // operation walks the stored entries
    logic scan_done;  // all entries read and compared
  } vst_sts_t;

endpackage

// ----- sv/vst_ram.sv -----
// ----------------------------------------------------------------------------
// vst_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module vst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/vst_dp.sv -----
// ----------------------------------------------------------------------------
// vst_dp
// Datapath of the value set table: entry store, fill count, scan pointers,
// compare against the key and the result register.
// ----------------------------------------------------------------------------
module vst_dp
  import vst_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  vst_cmd_t cmd,
  output vst_sts_t sts,
  input  vst_in_t  in_data,
  output vst_out_t out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  logic [1:0]         op;
  logic [VALUE_W-1:0] key;
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      rd_idx;
  logic [CW-1:0]      keep;
  logic               rd_pend;
  logic               found;
  logic               status;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [VALUE_W-1:0] wdata;
  logic               re;
  logic [VALUE_W-1:0] rdata;
  logic               hit;
  logic               more;

  assign more = (rd_idx < cnt);
  assign re   = cmd.scan && more;
  assign hit  = (rdata == key);

  assign sts.op_scan   = (op == OP_REMOVE) || (op == OP_QUERY);
  assign sts.scan_done = !more && !rd_pend;

  // write port: append on insert, move a kept entry down on remove
  always_comb begin
    we    = 1'b0;
    waddr = cnt[AW-1:0];
    wdata = key;
    if (cmd.exec && op == OP_INSERT && cnt < CAP) begin
      we = 1'b1;
    end
    if (cmd.scan && rd_pend && !hit && op == OP_REMOVE) begin
      we    = 1'b1;
      waddr = keep[AW-1:0];
      wdata = rdata;
    end
  end

  vst_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rdata)
  );

  // operation registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= in_data.opcode;
      key <= in_data.value;
    end
  end

  // count, scan pointers and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      rd_idx  <= '0;
      keep    <= '0;
      rd_pend <= 1'b0;
      found   <= 1'b0;
      status  <= 1'b0;
    end else begin
      if (cmd.load) begin
        rd_idx  <= '0;
        keep    <= '0;
        rd_pend <= 1'b0;
        found   <= 1'b0;
        status  <= 1'b0;
      end
      if (cmd.exec && op == OP_INSERT) begin
        if (cnt < CAP) begin
          cnt <= cnt + CW'(1);
        end else begin
          status <= 1'b1;
        end
      end
      if (cmd.scan) begin
        rd_pend <= more;
        if (more) begin
          rd_idx <= rd_idx + CW'(1);
        end
        if (rd_pend) begin
          if (hit) begin
            found <= 1'b1;
          end else begin
            keep <= keep + CW'(1);
          end
        end
      end
      if (cmd.close && op == OP_REMOVE) begin
        cnt <= keep;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_data.found       <= found;
      out_data.status      <= status;
      out_data.entry_count <= COUNT_W'(cnt);
    end
  end

  a_cnt_bound : assert property (@(posedge clk) disable iff (rst)
    cnt <= CAP)
    else $error("fill count above capacity");

  a_keep_behind : assert property (@(posedge clk) disable iff (rst)
    keep <= rd_idx)
    else $error("compaction pointer ahead of read pointer");

  a_close_shrinks : assert property (@(posedge clk) disable iff (rst)
    cmd.close |=> cnt <= $past(cnt))
    else $error("scan grew the table");

endmodule

// ----- sv/vst_ctrl.sv -----
// ----------------------------------------------------------------------------
// vst_ctrl
// Controller of the value set table: sequences one beat through execute,
// entry walk and result hand-off, and owns both handshakes.
// ----------------------------------------------------------------------------
module vst_ctrl
  import vst_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output vst_cmd_t cmd,
  input  vst_sts_t sts
);

  vst_state_t state;
  vst_state_t state_next;
  logic       out_valid_next;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.op_scan ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          cmd.close  = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.publish    = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_accept_exec : assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state == ST_EXEC)
    else $error("accepted beat not executed");

  a_publish_valid : assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> out_valid)
    else $error("result published without valid");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> out_free)
    else $error("pending result overwritten");

endmodule

// ----- sv/value_set_table.sv -----
// ----------------------------------------------------------------------------
// value_set_table
// Unordered table of 64-bit values with insert, remove-all and query.
// ----------------------------------------------------------------------------
// One beat is worked at a time. An insert (or the unused opcode) goes from
// accept through execute to the result register; a remove or query walks
// every stored entry through the single read port of the entry RAM, one entry
// per cycle, before its result is registered. The next beat is accepted once
// the result is registered, whether or not it has been taken yet; a result
// only waits in the controller while the previous one is still stalled.
// Remove compacts the survivors in place during the same walk. There is no
// clearing pass after reset: entries at or above the fill count are never
// read. entry_count carries the low five bits of the count.
// ----------------------------------------------------------------------------
module value_set_table
  import vst_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  vst_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output vst_out_t out_data
);

  vst_cmd_t cmd;
  vst_sts_t sts;

  // sequencing
  vst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // storage and compare
  vst_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
